// File: sv/encoder_frame_crc_checker_core_assert.svh
// Assertion macros shared by the checker of the encoder frame CRC checker.
`ifndef ENCODER_FRAME_CRC_CHECKER_CORE_ASSERT_SVH
`define ENCODER_FRAME_CRC_CHECKER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock and held off in reset.
`define EFCC_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("encoder frame CRC checker: assertion failed");

// Next-cycle implication, sampled on the rising clock and held off in reset.
`define EFCC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("encoder frame CRC checker: assertion failed");

`endif

// File: sv/efcc_pkg.sv
// Package of the encoder frame CRC checker: types, constants and the CRC function.
package efcc_pkg;

    localparam int WINDOW_COUNT_DEF = 4;
    localparam int SKIP_NEWEST_DEF  = 3;
    localparam int QUEUE_DEPTH_DEF  = 4;

    // Input opcodes.
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Offset that turns the unsigned angle into a signed position.
    localparam logic [15:0] POS_OFFSET = 16'h8000;

    typedef struct packed {
        logic       is_tick;
        logic [7:0] data;
    } t_cmd;

    // CRC x^8+x^3+1, seeded with the high byte, low byte fed MSB first.
    function automatic logic [7:0] crc8_angle(input logic [15:0] angle);
        logic [7:0] r;
        logic [7:0] d;
        logic       fb;
        r = angle[15:8];
        d = angle[7:0];
        for (int k = 0; k < 8; k++) begin
            fb = r[7];
            r  = {r[6:3], r[2] ^ fb, r[1:0], fb ^ d[7]};
            d  = {d[6:0], 1'b0};
        end
        return r;
    endfunction

endpackage

// File: sv/efcc_front.sv
// Front end: accepts input beats, classifies them and pushes commands into the queue.
module efcc_front (
    input  logic             i_valid,
    input  logic             i_opcode,
    input  logic [7:0]       i_rx_byte,
    input  logic             i_full,
    output logic             o_stall,
    output logic             o_push,
    output efcc_pkg::t_cmd   o_cmd
);

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        o_cmd = '0;
        unique case (i_opcode)
            efcc_pkg::OP_BYTE: begin
                o_cmd.is_tick = 1'b0;
                o_cmd.data    = i_rx_byte;
            end
            efcc_pkg::OP_TICK: begin
                // The byte lane carries nothing on a tick.
                o_cmd.is_tick = 1'b1;
                o_cmd.data    = '0;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// File: sv/efcc_queue.sv
// Short command queue between the front end and the back end.
module efcc_queue #(
    parameter int DEPTH = efcc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  efcc_pkg::t_cmd   i_cmd,
    output logic             o_full,
    output logic             o_valid,
    output efcc_pkg::t_cmd   o_cmd,
    input  logic             i_pop
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    efcc_pkg::t_cmd  r_mem [DEPTH];
    logic [AW-1:0]   r_wr, n_wr;
    logic [AW-1:0]   r_rd, n_rd;
    logic [CW-1:0]   r_count, n_count;
    logic            w_push;
    logic            w_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (w_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (w_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        case ({w_push, w_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

// File: sv/efcc_back.sv
// Back end: byte history, frame window search with CRC check and the result register.
module efcc_back #(
    parameter int WINDOW_COUNT = efcc_pkg::WINDOW_COUNT_DEF,
    parameter int SKIP_NEWEST  = efcc_pkg::SKIP_NEWEST_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  efcc_pkg::t_cmd     i_cmd,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_position,
    output logic [15:0]        o_raw_angle,
    output logic               o_error_flag
);

    localparam int HIST_DEPTH = SKIP_NEWEST + WINDOW_COUNT + 3;

    logic [7:0]        r_hist [HIST_DEPTH];
    logic [15:0]       r_held, n_held;
    logic              r_out_valid;
    logic signed [15:0] r_pos;
    logic [15:0]       r_raw;
    logic              r_err;

    logic [15:0]       w_angle [WINDOW_COUNT];
    logic [WINDOW_COUNT-1:0] w_hit;
    logic              w_found;
    logic [15:0]       w_sel;
    logic              w_slot;

    for (genvar w = 0; w < WINDOW_COUNT; w++) begin : g_win
        logic [7:0] b0, b1, b2, b3;
        logic [7:0] crc;
        logic       marks;
        assign b0 = r_hist[SKIP_NEWEST + w + 3];
        assign b1 = r_hist[SKIP_NEWEST + w + 2];
        assign b2 = r_hist[SKIP_NEWEST + w + 1];
        assign b3 = r_hist[SKIP_NEWEST + w];
        assign w_angle[w] = {b0[2], b1[6:0], b0[1], b2[6:0]};
        assign crc        = {b0[0], b3[6:0]};
        assign marks      = !b0[7] && b1[7] && b2[7] && b3[7];
        assign w_hit[w]   = marks && (efcc_pkg::crc8_angle(w_angle[w]) == crc);
    end

    // The newest window wins, so the loop runs from the oldest down.
    always_comb begin
        w_sel = r_held;
        for (int w = WINDOW_COUNT - 1; w >= 0; w--) begin
            if (w_hit[w]) begin
                w_sel = w_angle[w];
            end
        end
    end

    assign w_found = |w_hit;
    assign n_held  = w_sel;

    // A tick needs a free result slot; a byte beat never waits.
    assign w_slot = !r_out_valid || !i_stall;
    assign o_pop  = i_valid && (!i_cmd.is_tick || w_slot);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HIST_DEPTH; i++) begin
                r_hist[i] <= '0;
            end
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop && !i_cmd.is_tick) begin
                r_hist[0] <= i_cmd.data;
                for (int i = 1; i < HIST_DEPTH; i++) begin
                    r_hist[i] <= r_hist[i-1];
                end
            end
            if (o_pop && i_cmd.is_tick) begin
                r_held      <= n_held;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_cmd.is_tick) begin
            r_pos <= signed'(n_held ^ efcc_pkg::POS_OFFSET);
            r_raw <= n_held;
            r_err <= !w_found;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_position   = r_pos;
    assign o_raw_angle  = r_raw;
    assign o_error_flag = r_err;

endmodule

// File: sv/encoder_frame_crc_checker_core.sv
// Throughput: one input beat per cycle, byte or tick, while results are taken.
// A tick's result is registered in the back end after the tick has passed through the queue; bytes give none.
// The queue of QUEUE_DEPTH entries lets a tick wait on a stalled result without losing bytes.
// The window search and CRC for all windows evaluate combinationally from the byte history.
// Synchronous active-low reset clears the history, the held angle and the queue.
module encoder_frame_crc_checker_core #(
    parameter int WINDOW_COUNT = efcc_pkg::WINDOW_COUNT_DEF,
    parameter int SKIP_NEWEST  = efcc_pkg::SKIP_NEWEST_DEF,
    parameter int QUEUE_DEPTH  = efcc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_opcode,
    input  logic [7:0]         i_rx_byte,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_position,
    output logic [15:0]        o_raw_angle,
    output logic               o_error_flag
);

    logic            w_full;
    logic            w_push;
    efcc_pkg::t_cmd  w_front_cmd;
    logic            w_q_valid;
    efcc_pkg::t_cmd  w_q_cmd;
    logic            w_pop;

    efcc_front u_front (
        .i_valid   (i_valid),
        .i_opcode  (i_opcode),
        .i_rx_byte (i_rx_byte),
        .i_full    (w_full),
        .o_stall   (o_stall),
        .o_push    (w_push),
        .o_cmd     (w_front_cmd)
    );

    efcc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd),
        .i_pop   (w_pop)
    );

    efcc_back #(
        .WINDOW_COUNT (WINDOW_COUNT),
        .SKIP_NEWEST  (SKIP_NEWEST)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_q_valid),
        .i_cmd        (w_q_cmd),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_position   (o_position),
        .o_raw_angle  (o_raw_angle),
        .o_error_flag (o_error_flag)
    );

endmodule

// File: sv/efcc_checker.sv
// Port-level checker for the encoder frame CRC checker, bound to the top level.
`include "encoder_frame_crc_checker_core_assert.svh"

module efcc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [15:0] o_position,
    input logic [15:0]        o_raw_angle,
    input logic               o_error_flag
);

    logic        r_seen;
    logic        r_seen_ok;
    logic [15:0] r_last_raw;
    logic        w_out_beat;
    logic        w_out_hold;
    logic        w_pos_ok;
    logic        w_err_repeat;

    assign w_out_beat   = o_valid && !i_stall;
    assign w_out_hold   = o_valid && i_stall;
    assign w_pos_ok     = (o_position == signed'(o_raw_angle ^ efcc_pkg::POS_OFFSET));
    assign w_err_repeat = o_valid && o_error_flag && r_seen;

    // Remember the angle of the last delivered result and whether a good frame was seen.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen     <= 1'b0;
            r_seen_ok  <= 1'b0;
            r_last_raw <= '0;
        end else if (w_out_beat) begin
            r_seen     <= 1'b1;
            r_last_raw <= o_raw_angle;
            if (!o_error_flag) begin
                r_seen_ok <= 1'b1;
            end
        end
    end

    `EFCC_ASSERT_IMPL(a_pos_matches_raw, o_valid, w_pos_ok)
    `EFCC_ASSERT_IMPL(a_error_keeps_angle, w_err_repeat, o_raw_angle == r_last_raw)
    `EFCC_ASSERT_IMPL(a_zero_before_good, o_valid && !r_seen_ok, o_raw_angle == '0 || !o_error_flag)
    `EFCC_ASSERT_NEXT(a_stall_holds, w_out_hold, o_valid && $stable({o_raw_angle, o_error_flag}))

endmodule

bind encoder_frame_crc_checker_core efcc_checker u_efcc_checker (.*);
